FILE: rtl/crf_pkg.sv
`timescale 1ns / 1ps
// Shared types, register numbers and helper functions for the RTC/CMOS register file.
// Used by crf_fmt and cmos_rtc_register_file; depends on nothing else.
package crf_pkg;

    // Request kinds.
    localparam logic [1:0] KIND_SET_INDEX = 2'd0;
    localparam logic [1:0] KIND_WRITE     = 2'd1;
    localparam logic [1:0] KIND_READ      = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TYPE_NUMBER = 2'd0;
    localparam logic [1:0] CFG_SMALL_MAP   = 2'd1;
    localparam logic [1:0] CFG_FROZEN_TIME = 2'd2;

    // Register numbers with special read behaviour.
    localparam logic [7:0] REG_SECONDS  = 8'd0;
    localparam logic [7:0] REG_MINUTES  = 8'd2;
    localparam logic [7:0] REG_HOURS    = 8'd4;
    localparam logic [7:0] REG_WEEKDAY  = 8'd6;
    localparam logic [7:0] REG_DAY      = 8'd7;
    localparam logic [7:0] REG_MONTH    = 8'd8;
    localparam logic [7:0] REG_YEAR     = 8'd9;
    localparam logic [7:0] REG_STATUS_A = 8'd10;
    localparam logic [7:0] REG_STATUS_B = 8'd11;
    localparam logic [7:0] REG_STATUS_C = 8'd12;
    localparam logic [7:0] REG_STATUS_D = 8'd13;

    localparam logic [7:0] SMALL_MAP_MASK = 8'h3F;
    localparam logic [7:0] STATUS_A_FIXED = 8'h20;
    localparam logic [7:0] STATUS_B_FIXED = 8'h02;
    localparam logic [7:0] STATUS_C_UF    = 8'h10;
    localparam logic [7:0] STATUS_D_FIXED = 8'h80;
    localparam int         STATUS_B_BIN   = 2;

    // Formatted read result; use_store selects the stored byte instead of data.
    typedef struct packed {
        logic       use_store;
        logic [7:0] data;
    } rd_fmt_t;

    // Binary to BCD for values below one hundred, or plain binary when asked.
    function automatic logic [7:0] to_code(input logic [6:0] v, input logic binary);
        logic [3:0] tens;
        logic [6:0] ones;
        tens = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (v >= 7'(k * 10))
            begin
                tens = tens + 4'd1;
            end
        end
        ones = v - 7'(7'(tens) * 7'd10);
        if (binary)
        begin
            return {1'b0, v};
        end
        return {tens, ones[3:0]};
    endfunction

    // One plus (wday + 8 - type) modulo seven; the sum always lies in 1..15.
    function automatic logic [7:0] weekday_code(input logic [2:0] wday,
                                                input logic [2:0] tnum);
        logic [3:0] s;
        logic [3:0] m;
        s = {1'b0, wday} + 4'd8 - {1'b0, tnum};
        if (s >= 4'd14)
        begin
            m = s - 4'd14;
        end
        else if (s >= 4'd7)
        begin
            m = s - 4'd7;
        end
        else
        begin
            m = s;
        end
        return {4'd0, m} + 8'd1;
    endfunction

endpackage

FILE: rtl/crf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds no reset and depends on no package.
module crf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/crf_fmt.sv
`timescale 1ns / 1ps
// Read formatter: turns a register number and the current time into the read byte.
// Depends on crf_pkg for register numbers and the BCD and weekday helpers.
module crf_fmt (
    input  logic            binary_mode,
    input  logic [7:0]      addr,
    input  logic [3:0]      status_a_lo,
    input  logic            flag,
    input  logic [2:0]      type_number,
    input  logic [5:0]      now_second,
    input  logic [5:0]      now_minute,
    input  logic [4:0]      now_hour,
    input  logic [2:0]      now_weekday,
    input  logic [4:0]      now_day,
    input  logic [3:0]      now_month,
    input  logic [6:0]      now_year,
    output crf_pkg::rd_fmt_t fmt
);
    import crf_pkg::*;

    logic [6:0] year_mod;

    // The year field can reach 127, so fold it below one hundred first.
    assign year_mod = (now_year >= 7'd100) ? (now_year - 7'd100) : now_year;

    always_comb
    begin
        fmt.use_store = 1'b0;
        fmt.data      = 8'd0;
        case (addr)
            REG_SECONDS:  fmt.data = to_code({1'b0, now_second}, binary_mode);
            REG_MINUTES:  fmt.data = to_code({1'b0, now_minute}, binary_mode);
            REG_HOURS:    fmt.data = to_code({2'b00, now_hour}, binary_mode);
            REG_WEEKDAY:  fmt.data = weekday_code(now_weekday, type_number);
            REG_DAY:      fmt.data = to_code({2'b00, now_day}, binary_mode);
            REG_MONTH:    fmt.data = to_code({3'b000, now_month}, binary_mode);
            REG_YEAR:     fmt.data = to_code(year_mod, binary_mode);
            REG_STATUS_A: fmt.data = STATUS_A_FIXED | {4'd0, status_a_lo};
            REG_STATUS_B: fmt.data = STATUS_B_FIXED
                                   | (8'(binary_mode) << STATUS_B_BIN);
            REG_STATUS_C: fmt.data = flag ? STATUS_C_UF : 8'd0;
            REG_STATUS_D: fmt.data = STATUS_D_FIXED;
            default:      fmt.use_store = 1'b1;
        endcase
    end

endmodule

FILE: rtl/cmos_rtc_register_file.sv
`timescale 1ns / 1ps
// RTC/CMOS register file top level: index register, byte store, read pipeline.
// A read passes through the first stage registers and then the output register to read_data; out_stall can hold it.
// Throughput: one request per cycle while in_stall is low; the store RAM has one write and one read port.
// Index and write requests finish at acceptance and give no result.
// Reset clears the index, flags, configuration and per-entry valid bits at once,
// so the store reads as zero until written; there is no clearing pass.
module cmos_rtc_register_file #(
    parameter int STORE_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [7:0] value,
    input  logic [5:0] now_second,
    input  logic [5:0] now_minute,
    input  logic [4:0] now_hour,
    input  logic [2:0] now_weekday,
    input  logic [4:0] now_day,
    input  logic [3:0] now_month,
    input  logic [6:0] now_year,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [2:0] cfg_data
);
    import crf_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    logic [2:0]             type_number_reg;
    logic                   small_map_reg;
    logic                   frozen_time_reg;
    logic [7:0]             index_reg;
    logic [5:0]             last_sec_reg;
    logic                   upd_flag_reg;
    logic                   upd_flag_next;
    logic [3:0]             status_a_lo_reg;
    logic                   binary_reg;
    logic [STORE_DEPTH-1:0] vld_reg;

    logic                   s1_vld_reg;
    rd_fmt_t                s1_fmt_reg;
    logic                   s1_hit_reg;
    logic                   out_vld_reg;
    logic [7:0]             out_data_reg;

    logic       acc;
    logic       acc_read;
    logic       acc_write;
    logic [7:0] eff_idx;
    logic       in_range;
    logic       time_class;
    logic       raise;
    logic       s1_adv;
    logic [7:0] ram_q;
    logic [7:0] s1_byte;
    rd_fmt_t    fmt;

    assign acc       = in_valid && !in_stall;
    assign acc_read  = acc && (kind == KIND_READ);
    assign acc_write = acc && (kind == KIND_WRITE);

    assign eff_idx  = small_map_reg ? (index_reg & SMALL_MAP_MASK) : index_reg;
    assign in_range = {1'b0, eff_idx} < 9'(STORE_DEPTH);

    assign time_class = (eff_idx == REG_SECONDS) || (eff_idx == REG_MINUTES)
                     || (eff_idx == REG_HOURS)   || (eff_idx == REG_WEEKDAY)
                     || (eff_idx == REG_DAY)     || (eff_idx == REG_MONTH)
                     || (eff_idx == REG_YEAR)    || (eff_idx == REG_STATUS_C);

    // A status C read reports a seconds change seen by its own request.
    assign raise = acc_read && time_class && !frozen_time_reg
                && (now_second != last_sec_reg);

    always_comb
    begin
        upd_flag_next = upd_flag_reg;
        if (acc_read && (eff_idx == REG_STATUS_C))
        begin
            upd_flag_next = 1'b0;
        end
        else if (raise)
        begin
            upd_flag_next = 1'b1;
        end
    end

    crf_fmt u_fmt (
        .binary_mode (binary_reg),
        .addr        (eff_idx),
        .status_a_lo (status_a_lo_reg),
        .flag        (upd_flag_reg || raise),
        .type_number (type_number_reg),
        .now_second  (now_second),
        .now_minute  (now_minute),
        .now_hour    (now_hour),
        .now_weekday (now_weekday),
        .now_day     (now_day),
        .now_month   (now_month),
        .now_year    (now_year),
        .fmt         (fmt)
    );

    crf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (acc_write && in_range),
        .waddr (eff_idx[AW-1:0]),
        .wdata (value),
        .re    (acc_read),
        .raddr (eff_idx[AW-1:0]),
        .rdata (ram_q)
    );

    // The first stage holds a read until the output register can take it.
    assign s1_adv   = s1_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = s1_vld_reg && !s1_adv;
    assign s1_byte  = s1_fmt_reg.use_store ? (s1_hit_reg ? ram_q : 8'd0)
                                           : s1_fmt_reg.data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_number_reg <= 3'd0;
            small_map_reg   <= 1'b0;
            frozen_time_reg <= 1'b0;
            index_reg       <= 8'd0;
            last_sec_reg    <= 6'd0;
            upd_flag_reg    <= 1'b0;
            status_a_lo_reg <= 4'd0;
            binary_reg      <= 1'b0;
            vld_reg         <= '0;
            s1_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_TYPE_NUMBER: type_number_reg <= cfg_data;
                    CFG_SMALL_MAP:   small_map_reg   <= cfg_data[0];
                    CFG_FROZEN_TIME: frozen_time_reg <= cfg_data[0];
                    default:         ;
                endcase
            end
            if (acc && (kind == KIND_SET_INDEX))
            begin
                index_reg <= value;
            end
            if (acc_write && in_range)
            begin
                vld_reg[eff_idx[AW-1:0]] <= 1'b1;
                if (eff_idx == REG_STATUS_A)
                begin
                    status_a_lo_reg <= value[3:0];
                end
                if (eff_idx == REG_STATUS_B)
                begin
                    binary_reg <= value[STATUS_B_BIN];
                end
            end
            if (raise)
            begin
                last_sec_reg <= now_second;
            end
            upd_flag_reg <= upd_flag_next;

            if (acc_read)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_vld_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_read)
        begin
            s1_fmt_reg <= fmt;
            s1_hit_reg <= in_range && vld_reg[eff_idx[AW-1:0]];
        end
        if (s1_adv)
        begin
            out_data_reg <= s1_byte;
        end
    end

    assign out_valid = out_vld_reg;
    assign read_data = out_data_reg;

`ifndef SYNTH
    a_read_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
        acc_read |=> s1_vld_reg)
        else $error("accepted read did not reach the first stage");

    a_status_c_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_read && (eff_idx == REG_STATUS_C)) |=> !upd_flag_reg)
        else $error("update flag not cleared by status C read");

    a_frozen_holds_sec: assert property (@(posedge clk) disable iff (!rst_n)
        frozen_time_reg |=> $stable(last_sec_reg))
        else $error("last seconds value changed in fixed time mode");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && out_vld_reg && out_stall) |-> in_stall)
        else $error("request accepted while both stages are full");
`endif

endmodule
